// ----- sv/gha_pkg.sv -----
package gha_pkg;

   // request operation codes
   typedef logic [1:0] func_type;
   localparam func_type FUNC_CREATE   = 2'd0;
   localparam func_type FUNC_DESTROY  = 2'd1;
   localparam func_type FUNC_VALIDATE = 2'd2;

   // response status codes
   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK     = 2'd0;
   localparam status_type STATUS_FULL   = 2'd1;
   localparam status_type STATUS_REJECT = 2'd2;

   // handle layout: generation in the upper half, slot in the lower half
   localparam int HANDLE_W = 32;
   localparam int GEN_W    = 16;
   localparam int SLOT_F_W = 16;

   typedef logic [HANDLE_W-1:0] handle_type;
   typedef logic [GEN_W-1:0]    gen_type;
   typedef logic [SLOT_F_W-1:0] slot_field_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic accept;  // capture request and launch the slot table read
      logic commit;  // update state and load the response register
   } cmd_type;

endpackage

// ----- sv/gha_if.sv -----
interface gha_req_if;
   logic                  valid;
   logic                  ready;
   gha_pkg::func_type     func;
   gha_pkg::handle_type   handle;

   modport source (output valid, output func, output handle, input ready);
   modport sink   (input valid, input func, input handle, output ready);
endinterface

interface gha_rsp_if;
   logic                  valid;
   logic                  ready;
   gha_pkg::handle_type   new_handle;
   gha_pkg::status_type   status;

   modport source (output valid, output new_handle, output status, input ready);
   modport sink   (input valid, input new_handle, input status, output ready);
endinterface

// ----- sv/generational_handle_allocator.sv -----
// generational handle allocator
// req_if carries one operation per item: func (create, destroy, validate)
// and a 32-bit handle (generation in the upper half, slot in the lower).
// rsp_if returns exactly one item per request: new_handle (non-zero only
// for a successful create) and status (ok, table full, rejected).
// a request accepted at one edge is read from the slot table into a
// register; the execute step commits once the output register is free,
// and the response is registered at that commit.
// a new item is taken only after the last one commits; the single-port
// slot table is read at accept and written back at commit.
// a finished response waits in the output register while the next item
// is accepted; if the receiver still stalls, the second item holds in
// the execute step until the output register frees.
// reset clears the free list and the fill count of never-used slots;
// the slot table needs no clearing pass, since entries at or above the fill
// count are never read as valid.
module generational_handle_allocator #(
   parameter int SLOTS = 64
) (
   input  logic       clock,
   input  logic       reset,
   gha_req_if.sink    req_if,
   gha_rsp_if.source  rsp_if
);

   gha_pkg::cmd_type cmd;

   // handshake sequencing
   gha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd)
   );

   // slot table and free list
   gha_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_func       (req_if.func),
      .req_handle     (req_if.handle),
      .rsp_new_handle (rsp_if.new_handle),
      .rsp_status     (rsp_if.status)
   );

endmodule

// ----- sv/gha_ctrl.sv -----
module gha_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output gha_pkg::cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   // handshake and command decode
   always_comb begin
      req_ready  = (state_ff == ST_IDLE);
      out_free   = !rsp_valid_ff || rsp_ready;
      cmd.accept = req_valid && req_ready;
      cmd.commit = (state_ff == ST_EXEC) && out_free;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (cmd.commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response valid flag
   always_comb begin
      priority if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- sv/gha_datapath.sv -----
module gha_datapath #(
   parameter int SLOTS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  gha_pkg::cmd_type    cmd,
   input  gha_pkg::func_type   req_func,
   input  gha_pkg::handle_type req_handle,
   output gha_pkg::handle_type rsp_new_handle,
   output gha_pkg::status_type rsp_status
);

   localparam int SW    = $clog2(SLOTS);
   localparam int LW    = $clog2(SLOTS + 1);
   localparam int GW    = gha_pkg::GEN_W;
   localparam int EW    = 1 + GW + LW;
   localparam int ACT_B = EW - 1;
   localparam int GEN_H = EW - 2;

   // slot table: active bit, generation, free-list link
   logic [EW-1:0] table_mem [SLOTS];
   logic [EW-1:0] rd_data_ff;

   logic [SW-1:0] free_head_ff, free_head_in;
   logic          free_empty_ff, free_empty_in;
   logic [LW-1:0] fresh_count_ff, fresh_count_in;

   gha_pkg::func_type       func_ff;
   gha_pkg::slot_field_type slot_ff;
   gha_pkg::gen_type        gen_req_ff;
   logic [SW-1:0]           addr_ff;
   gha_pkg::handle_type     new_handle_ff, new_handle_in;
   gha_pkg::status_type     status_ff, status_in;

   logic          from_list, fresh_avail;
   logic [SW-1:0] rd_addr;
   logic          wr_en;
   logic [EW-1:0] wr_data;
   logic          rd_active, slot_used, in_range, link_ok;
   gha_pkg::gen_type rd_gen;
   logic [LW-1:0] rd_link;

   // create source: free list first, then never-used slots
   assign from_list   = !free_empty_ff && (LW'(free_head_ff) < LW'(SLOTS));
   assign fresh_avail = fresh_count_ff < LW'(SLOTS);

   // table read address at accept
   always_comb begin
      if (req_func == gha_pkg::FUNC_CREATE) begin
         rd_addr = from_list ? free_head_ff : fresh_count_ff[SW-1:0];
      end else begin
         rd_addr = req_handle[SW-1:0];
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff    <= req_func;
         slot_ff    <= req_handle[gha_pkg::SLOT_F_W-1:0];
         gen_req_ff <= req_handle[gha_pkg::HANDLE_W-1:gha_pkg::SLOT_F_W];
         addr_ff    <= rd_addr;
      end
   end

   // slot table port: registered read at accept, write at commit
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rd_data_ff <= table_mem[rd_addr];
      end
      if (cmd.commit && wr_en) begin
         table_mem[addr_ff] <= wr_data;
      end
   end

   // entry fields; entries at or above the fill count were never written
   assign rd_active = rd_data_ff[ACT_B];
   assign rd_gen    = rd_data_ff[GEN_H -: GW];
   assign rd_link   = rd_data_ff[LW-1:0];
   assign link_ok   = rd_link < LW'(SLOTS);
   assign in_range  = 17'(slot_ff) < 17'(SLOTS);
   assign slot_used = 17'(slot_ff) < 17'(fresh_count_ff);

   // operation execute
   always_comb begin
      wr_en          = 1'b0;
      wr_data        = rd_data_ff;
      new_handle_in  = '0;
      status_in      = gha_pkg::STATUS_REJECT;
      free_head_in   = free_head_ff;
      free_empty_in  = free_empty_ff;
      fresh_count_in = fresh_count_ff;
      unique case (func_ff)
         gha_pkg::FUNC_CREATE: begin
            if (from_list) begin
               wr_en          = 1'b1;
               wr_data[ACT_B] = 1'b1;
               new_handle_in  = {rd_gen, gha_pkg::SLOT_F_W'(addr_ff)};
               status_in      = gha_pkg::STATUS_OK;
               if (link_ok) begin
                  free_head_in = rd_link[SW-1:0];
               end else begin
                  free_head_in  = '0;
                  free_empty_in = 1'b1;
               end
            end else if (fresh_avail) begin
               wr_en          = 1'b1;
               wr_data        = {1'b1, GW'(0), LW'(SLOTS)};
               new_handle_in  = {GW'(0), gha_pkg::SLOT_F_W'(addr_ff)};
               status_in      = gha_pkg::STATUS_OK;
               fresh_count_in = fresh_count_ff + LW'(1);
               free_empty_in  = 1'b1;
            end else begin
               status_in = gha_pkg::STATUS_FULL;
            end
         end
         gha_pkg::FUNC_DESTROY: begin
            if (slot_used && rd_active) begin
               wr_en         = 1'b1;
               wr_data       = {1'b0, rd_gen + GW'(1),
                                free_empty_ff ? LW'(SLOTS) : LW'(free_head_ff)};
               status_in     = gha_pkg::STATUS_OK;
               free_head_in  = addr_ff;
               free_empty_in = 1'b0;
            end
         end
         gha_pkg::FUNC_VALIDATE: begin
            if (in_range && slot_used && rd_active && (rd_gen == gen_req_ff)) begin
               status_in = gha_pkg::STATUS_OK;
            end
         end
         default: begin
            status_in = gha_pkg::STATUS_REJECT;
         end
      endcase
   end

   // allocator state
   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff   <= '0;
         free_empty_ff  <= 1'b1;
         fresh_count_ff <= '0;
      end else if (cmd.commit) begin
         free_head_ff   <= free_head_in;
         free_empty_ff  <= free_empty_in;
         fresh_count_ff <= fresh_count_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         new_handle_ff <= new_handle_in;
         status_ff     <= status_in;
      end
   end

   assign rsp_new_handle = new_handle_ff;
   assign rsp_status     = status_ff;

endmodule

// ----- sv/gha_checker.sv -----
module gha_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input gha_pkg::handle_type rsp_new_handle,
   input gha_pkg::status_type rsp_status
);

   // stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                  && $stable(rsp_new_handle))
      else $error("response changed while stalled");

   // a response with a failing status carries no handle
   a_handle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != gha_pkg::STATUS_OK) |-> rsp_new_handle == '0)
      else $error("handle given with a failing status");

   // one item in flight: no accept right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous item executes");

   // reset empties the response register
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind generational_handle_allocator gha_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_new_handle (rsp_if.new_handle),
   .rsp_status     (rsp_if.status)
);
